[design/ssme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted set merge engine.
// ----------------------------------------------------------------------------
package ssme_pkg;

   localparam int SET_DEPTH_DEFAULT = 32;
   localparam int ELEM_W            = 32;
   localparam int ACTION_W          = 2;
   localparam int MODE_W            = 2;

   localparam logic [ACTION_W-1:0] ACTION_LOAD_A = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_LOAD_B = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_RUN    = 2'd2;

   localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED  = 2'd3;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

[design/ssme_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_ctrl
// Controller: decodes request beats into load and run commands and
// sequences the pointer walk until the datapath reports it done.
// ----------------------------------------------------------------------------
module ssme_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ssme_pkg::ACTION_W-1:0]  action,
   input  ssme_pkg::status_type           status,
   output ssme_pkg::cmd_type              cmd,
   output logic                           busy
);
   import ssme_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_WALK = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               cmd.load_a = (action == ACTION_LOAD_A);
               cmd.load_b = (action == ACTION_LOAD_B);
               if (action == ACTION_RUN) begin
                  state_in = STATE_WALK;
               end
            end
         end
         STATE_WALK: begin
            if (status.walk_done) begin
               cmd.finish = 1'b1;
               state_in   = STATE_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == STATE_WALK);

endmodule

[design/ssme_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_datapath
// List stores, counts, walk pointers, compare/select and the one-deep
// pending result that lets the final beat carry its last flag.
// ----------------------------------------------------------------------------
module ssme_datapath #(
   parameter int SetDepth = ssme_pkg::SET_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ssme_pkg::MODE_W-1:0]         csr_write_data,
   input  logic signed [ssme_pkg::ELEM_W-1:0]  value,
   input  ssme_pkg::cmd_type                   cmd,
   output ssme_pkg::status_type                status,
   output logic                                rsp_strobe,
   output logic signed [ssme_pkg::ELEM_W-1:0]  rsp_element,
   output logic                                rsp_is_last,
   output logic                                rsp_is_empty
);
   import ssme_pkg::*;

   localparam int CW = $clog2(SetDepth + 1);
   localparam int AW = (SetDepth > 1) ? $clog2(SetDepth) : 1;

   logic [MODE_W-1:0] mode_ff;

   logic signed [ELEM_W-1:0] mem_a [SetDepth];
   logic signed [ELEM_W-1:0] mem_b [SetDepth];
   logic signed [ELEM_W-1:0] rd_a_ff;
   logic signed [ELEM_W-1:0] rd_b_ff;

   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] ptr_a_ff, ptr_a_in;
   logic [CW-1:0] ptr_b_ff, ptr_b_in;

   logic                     pend_valid_ff;
   logic signed [ELEM_W-1:0] pend_ff;

   logic                     strobe_ff;
   logic signed [ELEM_W-1:0] element_ff;
   logic                     last_ff;
   logic                     empty_ff;

   logic                     a_avail, b_avail, a_full, b_full;
   logic                     cand_valid, adv_a, adv_b, walk_done;
   logic signed [ELEM_W-1:0] cand;

   assign a_full  = (count_a_ff >= CW'(SetDepth));
   assign b_full  = (count_b_ff >= CW'(SetDepth));
   assign a_avail = (ptr_a_ff < count_a_ff);
   assign b_avail = (ptr_b_ff < count_b_ff);

   // one merge decision per cycle
   always_comb begin
      cand_valid = 1'b0;
      cand       = rd_a_ff;
      adv_a      = 1'b0;
      adv_b      = 1'b0;
      walk_done  = 1'b0;
      priority if (mode_ff == MODE_RESERVED) begin
         walk_done = 1'b1;
      end else if (a_avail && b_avail) begin
         if (rd_a_ff < rd_b_ff) begin
            adv_a      = 1'b1;
            cand_valid = (mode_ff != MODE_INTERSECT);
         end else if (rd_a_ff > rd_b_ff) begin
            adv_b      = 1'b1;
            cand_valid = (mode_ff == MODE_UNION);
            cand       = rd_b_ff;
         end else begin
            adv_a      = 1'b1;
            adv_b      = 1'b1;
            cand_valid = (mode_ff != MODE_DIFF);
         end
      end else if (a_avail && (mode_ff != MODE_INTERSECT)) begin
         adv_a      = 1'b1;
         cand_valid = 1'b1;
      end else if (b_avail && (mode_ff == MODE_UNION)) begin
         adv_b      = 1'b1;
         cand_valid = 1'b1;
         cand       = rd_b_ff;
      end else begin
         walk_done = 1'b1;
      end
   end

   assign status.walk_done = walk_done;

   always_comb begin
      ptr_a_in   = ptr_a_ff;
      ptr_b_in   = ptr_b_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cmd.finish) begin
         ptr_a_in   = '0;
         ptr_b_in   = '0;
         count_a_in = '0;
         count_b_in = '0;
      end else if (cmd.step) begin
         if (adv_a) begin
            ptr_a_in = ptr_a_ff + CW'(1);
         end
         if (adv_b) begin
            ptr_b_in = ptr_b_ff + CW'(1);
         end
      end
      if (cmd.load_a && !a_full) begin
         count_a_in = count_a_ff + CW'(1);
      end
      if (cmd.load_b && !b_full) begin
         count_b_in = count_b_ff + CW'(1);
      end
   end

   // stores: write at count, read at next pointer
   always_ff @(posedge clock) begin
      if (cmd.load_a && !a_full) begin
         mem_a[count_a_ff[AW-1:0]] <= value;
      end
      rd_a_ff <= mem_a[ptr_a_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b && !b_full) begin
         mem_b[count_b_ff[AW-1:0]] <= value;
      end
      rd_b_ff <= mem_b[ptr_b_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_UNION;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ptr_a_ff      <= '0;
         ptr_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ptr_a_ff   <= ptr_a_in;
         ptr_b_ff   <= ptr_b_in;
         strobe_ff  <= cmd.finish || (cmd.step && cand_valid && pend_valid_ff);
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.step && cand_valid) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   // pending beat goes out when a newer one arrives or the walk ends
   always_ff @(posedge clock) begin
      if (cmd.step && cand_valid) begin
         pend_ff <= cand;
      end
      if (cmd.finish) begin
         element_ff <= pend_valid_ff ? pend_ff : '0;
         last_ff    <= 1'b1;
         empty_ff   <= !pend_valid_ff;
      end else begin
         element_ff <= pend_ff;
         last_ff    <= 1'b0;
         empty_ff   <= 1'b0;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_element  = element_ff;
   assign rsp_is_last  = last_ff;
   assign rsp_is_empty = empty_ff;

endmodule

[design/sorted_set_merge_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_merge_engine
// Loads two ascending lists and merges them as union, intersection or
// A minus B, at most one result beat per merge decision.
//
// Channel   Ports                                   Handshake
// request   req_action, req_value                   start & !busy
// response  rsp_element, rsp_is_last, rsp_is_empty  rsp_strobe, one cycle
// config    csr_write_data                          csr_write_enable
//
// A load beat leaves busy low. A run beat raises busy while the walk takes
// its pointer steps (at most count A + count B) and then while it issues the
// finish command. A kept element is held until the next kept element or the
// finish command and leaves on the cycle after that; the last beat leaves on
// the cycle after the finish command. The walk is set by the two-pointer
// compare loop, one store read per list per cycle. Reset is synchronous and
// clears counts, mode and control; the stores need no clearing. The receiver
// cannot stall the response.
// ----------------------------------------------------------------------------
module sorted_set_merge_engine #(
   parameter int SetDepth = ssme_pkg::SET_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ssme_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [ssme_pkg::ELEM_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic signed [ssme_pkg::ELEM_W-1:0]  rsp_element,
   output logic                                rsp_is_last,
   output logic                                rsp_is_empty,
   input  logic                                csr_write_enable,
   input  logic [ssme_pkg::MODE_W-1:0]         csr_write_data
);
   import ssme_pkg::*;

   cmd_type    cmd;
   status_type status;

   ssme_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ssme_datapath #(
      .SetDepth (SetDepth)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .value            (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_element      (rsp_element),
      .rsp_is_last      (rsp_is_last),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
